FILE: hdl/tsfq_pkg.sv
package tsfq_pkg;

	// Width of the word fields on both channels and of the status field.
	localparam int DATA_W = 32;
	localparam int STATUS_W = 2;

	// Defaults for the top-level parameters.
	localparam int DEFAULT_STACK_DEPTH = 128;
	localparam int DEFAULT_WORD_BITS = 32;

	// Request actions.
	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		logic [STATUS_W-1:0]      status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_DEQ_CHK,
		S_MOVE,
		S_DEQ_OUT,
		S_EMPTY_OUT
	} state_t;

	// Selects what goes into the response register.
	typedef enum logic [1:0] {
		RES_OK,
		RES_FULL,
		RES_EMPTY,
		RES_DATA
	} res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     capture;
		logic     push;
		logic     pop;
		logic     move;
		logic     load;
		res_sel_t res_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_deq;
		logic in_full;
		logic in_empty;
		logic out_empty;
		logic move_pend;
		logic slot_free;
	} sts_t;

endpackage

FILE: hdl/tsfq_ctrl.sv
module tsfq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  tsfq_pkg::sts_t   sts,
	output tsfq_pkg::cmd_t   cmd
);

	tsfq_pkg::state_t state_q;
	tsfq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsfq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			tsfq_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = sts.req_deq ? tsfq_pkg::S_DEQ_CHK : tsfq_pkg::S_ENQ;
				end
			end
			tsfq_pkg::S_ENQ: begin
				if (sts.slot_free) begin
					state_d = tsfq_pkg::S_IDLE;
				end
			end
			tsfq_pkg::S_DEQ_CHK: begin
				if (!sts.out_empty) begin
					state_d = tsfq_pkg::S_DEQ_OUT;
				end else if (sts.in_empty) begin
					state_d = tsfq_pkg::S_EMPTY_OUT;
				end else begin
					state_d = tsfq_pkg::S_MOVE;
				end
			end
			tsfq_pkg::S_MOVE: begin
				// The last word read from the inbound stack must land before leaving.
				if (sts.in_empty && !sts.move_pend) begin
					state_d = tsfq_pkg::S_DEQ_CHK;
				end
			end
			tsfq_pkg::S_DEQ_OUT, tsfq_pkg::S_EMPTY_OUT: begin
				if (sts.slot_free) begin
					state_d = tsfq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tsfq_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		req_ready   = 1'b0;
		cmd         = '0;
		cmd.res_sel = tsfq_pkg::RES_OK;
		unique case (state_q)
			tsfq_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			tsfq_pkg::S_ENQ: begin
				if (sts.slot_free) begin
					cmd.load = 1'b1;
					if (sts.in_full) begin
						cmd.res_sel = tsfq_pkg::RES_FULL;
					end else begin
						cmd.push    = 1'b1;
						cmd.res_sel = tsfq_pkg::RES_OK;
					end
				end
			end
			tsfq_pkg::S_DEQ_CHK: begin
				cmd.pop = !sts.out_empty;
			end
			tsfq_pkg::S_MOVE: begin
				cmd.move = 1'b1;
			end
			tsfq_pkg::S_DEQ_OUT: begin
				cmd.load    = sts.slot_free;
				cmd.res_sel = tsfq_pkg::RES_DATA;
			end
			tsfq_pkg::S_EMPTY_OUT: begin
				cmd.load    = sts.slot_free;
				cmd.res_sel = tsfq_pkg::RES_EMPTY;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

endmodule

FILE: hdl/tsfq_dpath.sv
module tsfq_dpath #(
	parameter int STACK_DEPTH = tsfq_pkg::DEFAULT_STACK_DEPTH,
	parameter int WORD_BITS   = tsfq_pkg::DEFAULT_WORD_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tsfq_pkg::req_t req,
	input  tsfq_pkg::cmd_t cmd,
	output tsfq_pkg::sts_t sts,
	input  logic           rsp_ready,
	output logic           rsp_valid,
	output tsfq_pkg::rsp_t rsp
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	logic [tsfq_pkg::DATA_W-1:0] data_q;
	logic [WORD_BITS-1:0]        wr_word;
	logic [tsfq_pkg::DATA_W-1:0] rd_ext;

	logic [CNT_W-1:0] in_cnt_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [CNT_W-1:0] in_cnt_dec;
	logic [CNT_W-1:0] out_cnt_dec;
	logic             move_pend_q;
	logic             in_empty;
	logic             move_rd;
	logic             move_wr;

	logic [WORD_BITS-1:0] in_mem [STACK_DEPTH];
	logic [WORD_BITS-1:0] out_mem [STACK_DEPTH];
	logic [WORD_BITS-1:0] in_rdata_q;
	logic [WORD_BITS-1:0] out_rdata_q;

	logic           rsp_valid_q;
	tsfq_pkg::rsp_t rsp_q;
	tsfq_pkg::rsp_t rsp_d;

	// Only the low WORD_BITS bits of a word are kept; results are zero-extended.
	for (genvar i = 0; i < WORD_BITS; i++) begin : g_wr
		if (i < tsfq_pkg::DATA_W) begin : g_bit
			assign wr_word[i] = data_q[i];
		end else begin : g_zero
			assign wr_word[i] = 1'b0;
		end
	end

	for (genvar i = 0; i < tsfq_pkg::DATA_W; i++) begin : g_rd
		if (i < WORD_BITS) begin : g_bit
			assign rd_ext[i] = out_rdata_q[i];
		end else begin : g_zero
			assign rd_ext[i] = 1'b0;
		end
	end

	assign in_cnt_dec  = in_cnt_q - CNT_W'(1);
	assign out_cnt_dec = out_cnt_q - CNT_W'(1);
	assign in_empty    = (in_cnt_q == '0);
	assign move_rd     = cmd.move && !in_empty;
	assign move_wr     = cmd.move && move_pend_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			data_q <= req.data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			move_pend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				in_cnt_q <= in_cnt_q + CNT_W'(1);
			end else if (move_rd) begin
				in_cnt_q <= in_cnt_dec;
			end
			if (cmd.pop) begin
				out_cnt_q <= out_cnt_dec;
			end else if (move_wr) begin
				out_cnt_q <= out_cnt_q + CNT_W'(1);
			end
			if (cmd.move) begin
				move_pend_q <= move_rd;
			end
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Inbound stack: pushed from the request, read from the top during a refill.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			in_mem[in_cnt_q[ADDR_W-1:0]] <= wr_word;
		end
		if (move_rd) begin
			in_rdata_q <= in_mem[in_cnt_dec[ADDR_W-1:0]];
		end
	end

	// Outbound stack: each inbound read is written here in the cycle after it, popped on dequeue.
	always_ff @(posedge clk) begin
		if (move_wr) begin
			out_mem[out_cnt_q[ADDR_W-1:0]] <= in_rdata_q;
		end
		if (cmd.pop) begin
			out_rdata_q <= out_mem[out_cnt_dec[ADDR_W-1:0]];
		end
	end

	always_comb begin
		rsp_d = '0;
		unique case (cmd.res_sel)
			tsfq_pkg::RES_OK: begin
				rsp_d.status = tsfq_pkg::ST_OK;
			end
			tsfq_pkg::RES_FULL: begin
				rsp_d.status = tsfq_pkg::ST_FULL;
			end
			tsfq_pkg::RES_EMPTY: begin
				rsp_d.status = tsfq_pkg::ST_EMPTY;
			end
			tsfq_pkg::RES_DATA: begin
				rsp_d.status   = tsfq_pkg::ST_OK;
				rsp_d.data_out = rd_ext;
			end
			default: begin
				rsp_d.status = tsfq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts.req_deq   = (req.action == tsfq_pkg::ACT_DEQ);
	assign sts.in_full   = (in_cnt_q == CNT_W'(STACK_DEPTH));
	assign sts.in_empty  = in_empty;
	assign sts.out_empty = (out_cnt_q == '0);
	assign sts.move_pend = move_pend_q;
	assign sts.slot_free = !rsp_valid_q || rsp_ready;

endmodule

FILE: hdl/two_stack_fifo_queue.sv
// FIFO queue of signed words built from two LIFO stacks of STACK_DEPTH entries.
// A request (req_valid/req_ready, payload req) either enqueues req.data_in
// onto the inbound stack or dequeues the oldest word. Every request gives
// exactly one response (rsp_valid/rsp_ready, payload rsp) with a status of
// ok, inbound full (word dropped) or queue empty, and the word on a
// successful dequeue. The block works on one request at a time.
// An enqueue passes from idle to the enqueue state, which loads its response
// into the output register and returns to idle, where ready is high again.
// A dequeue first checks the stacks. If the outbound stack holds words, it
// starts a registered read of its top, and the response with that word is
// loaded in the state after; if the whole queue is empty, an empty response
// is loaded in the state after. A dequeue that finds the outbound stack empty
// but the inbound stack not first moves the whole inbound stack across, one
// word per cycle, then checks again. Each word moves across only once.
// Responses sit in an output register; while the receiver stalls, the next
// request is still accepted and worked on, and its response waits until the
// register is taken. Reset empties both stacks and drops any pending response;
// the stack memories themselves are not cleared.
module two_stack_fifo_queue #(
	parameter int STACK_DEPTH = tsfq_pkg::DEFAULT_STACK_DEPTH,
	parameter int WORD_BITS   = tsfq_pkg::DEFAULT_WORD_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tsfq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tsfq_pkg::rsp_t rsp
);

	tsfq_pkg::cmd_t cmd;
	tsfq_pkg::sts_t sts;

	// The controller sequences each request; the datapath holds the stacks.
	tsfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tsfq_dpath #(
		.STACK_DEPTH (STACK_DEPTH),
		.WORD_BITS   (WORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// A push must never be issued onto a full inbound stack.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && sts.in_full))
		else $error("push issued on a full inbound stack");

	// A pop must never be issued on an empty outbound stack.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.pop && sts.out_empty))
		else $error("pop issued on an empty outbound stack");

	// A response is only loaded when the output register is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> sts.slot_free)
		else $error("response overwritten before it was taken");

	// Once a request is accepted, no second one is taken in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in progress");

endmodule
